// ===== rtl/core/lpcs_pkg.sv =====
// Shared types and codes for the indicator line classifier.
// No dependencies; used by the interfaces, the line tracker and the top level.
`default_nettype none

package lpcs_pkg;

  // width of the edge threshold register
  localparam int THRESH_WIDTH = 16;

  // operation codes of an input item
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_EVALUATE = 1'b1;

  // line class
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOW  = 2'd0;
  localparam kind_t KIND_HIGH = 2'd1;
  localparam kind_t KIND_PWM  = 2'd2;

  // reported charge state
  typedef logic [1:0] charge_t;
  localparam charge_t STATE_NOT_CONNECTED = 2'd0;
  localparam charge_t STATE_CHARGING      = 2'd1;
  localparam charge_t STATE_FAULT         = 2'd2;

  // per-line control from the top level to a line tracker
  typedef struct packed {
    logic sample;    // count this level
    logic evaluate;  // window ends: clear counters
    logic level;     // sampled line level
  } line_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpcs_if.sv =====
// Valid/ready channel interfaces for sample items and result items.
// Depends on lpcs_pkg for the result field types.
`default_nettype none

interface lpcs_sample_if;
  logic valid;
  logic ready;
  logic operation;
  logic red_level;
  logic green_level;

  modport source (output valid, output operation, output red_level,
                  output green_level, input ready);
  modport sink   (input valid, input operation, input red_level,
                  input green_level, output ready);
endinterface

interface lpcs_result_if;
  logic                  valid;
  logic                  ready;
  lpcs_pkg::charge_t     charge_state;
  lpcs_pkg::kind_t       red_kind;
  lpcs_pkg::kind_t       green_kind;

  modport source (output valid, output charge_state, output red_kind,
                  output green_kind, input ready);
  modport sink   (input valid, input charge_state, input red_kind,
                  input green_kind, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpcs_line.sv =====
// One indicator line: saturating high/low/edge counters and the line class.
// Depends on lpcs_pkg.
`default_nettype none

module lpcs_line #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  lpcs_pkg::line_ctrl_t                 ctrl,
  input  wire [lpcs_pkg::THRESH_WIDTH-1:0]     threshold,
  output lpcs_pkg::kind_t                      kind
);

  localparam int CMP_WIDTH =
    (COUNT_WIDTH > lpcs_pkg::THRESH_WIDTH) ? COUNT_WIDTH : lpcs_pkg::THRESH_WIDTH;

  logic [COUNT_WIDTH-1:0] high_samples;
  logic [COUNT_WIDTH-1:0] low_samples;
  logic [COUNT_WIDTH-1:0] edges;
  logic                   previous;

  logic [COUNT_WIDTH-1:0] high_samples_next;
  logic [COUNT_WIDTH-1:0] low_samples_next;
  logic [COUNT_WIDTH-1:0] edges_next;
  logic                   toggled;

  assign toggled = ctrl.level != previous;

  // saturating increments
  assign high_samples_next = (&high_samples) ? high_samples : high_samples + 1'b1;
  assign low_samples_next  = (&low_samples)  ? low_samples  : low_samples + 1'b1;
  assign edges_next        = (&edges)        ? edges        : edges + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_samples <= '0;
      low_samples  <= '0;
      edges        <= '0;
      previous     <= 1'b0;
    end else if (ctrl.evaluate) begin
      // last level is kept across windows
      high_samples <= '0;
      low_samples  <= '0;
      edges        <= '0;
    end else if (ctrl.sample) begin
      if (ctrl.level) begin
        high_samples <= high_samples_next;
      end else begin
        low_samples <= low_samples_next;
      end
      if (toggled) begin
        previous <= ctrl.level;
        edges    <= edges_next;
      end
    end
  end

  // class of the window so far; a tie counts as low
  always_comb begin
    priority if (CMP_WIDTH'(edges) >= CMP_WIDTH'(threshold)) begin
      kind = lpcs_pkg::KIND_PWM;
    end else if (high_samples > low_samples) begin
      kind = lpcs_pkg::KIND_HIGH;
    end else begin
      kind = lpcs_pkg::KIND_LOW;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/led_pair_charge_state_classifier.sv =====
// Red/green charge indicator classifier: top level.
// Depends on lpcs_pkg, lpcs_if (lpcs_sample_if, lpcs_result_if) and lpcs_line.
//
// Takes one item per clock on the samples channel. A sample item (operation
// OP_SAMPLE) counts high samples, low samples and level changes for the red
// and green lines; these counters are COUNT_WIDTH bits and stick at full
// scale. A sample item produces no result. An evaluate item (OP_EVALUATE)
// classes each line from its window (PWM if its edge count is at or above
// edge_threshold, else high if high samples outnumber low ones, else low),
// clears the counters but keeps the last levels, and produces one result:
// fault if red is high or PWM, charging if green is high or PWM, else not
// connected. The result shows on the results channel the cycle after the
// evaluate item is taken, from a single result register. Throughput is one
// item per cycle; the samples channel stalls only while that register holds
// a result the sink has not taken. Both lines start with their last level low.
// edge_threshold resets to 4; users write it via cfg_write/cfg_data only while
// the block is idle (not enforced); a zero threshold classes all lines as PWM.
`default_nettype none

module led_pair_charge_state_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  lpcs_sample_if.sink                      samples,
  lpcs_result_if.source                    results,
  input  wire                              cfg_write,
  input  wire [lpcs_pkg::THRESH_WIDTH-1:0] cfg_data
);

  logic [lpcs_pkg::THRESH_WIDTH-1:0] edge_threshold;

  logic                 accept;
  logic                 eval_accept;
  lpcs_pkg::line_ctrl_t red_ctrl;
  lpcs_pkg::line_ctrl_t green_ctrl;
  lpcs_pkg::kind_t      red_kind_now;
  lpcs_pkg::kind_t      green_kind_now;
  lpcs_pkg::charge_t    charge_next;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= lpcs_pkg::THRESH_WIDTH'(4);
    end else if (cfg_write) begin
      edge_threshold <= cfg_data;
    end
  end

  // input side moves whenever the result register is free or being drained
  assign samples.ready = !results.valid || results.ready;
  assign accept        = samples.valid && samples.ready;
  assign eval_accept   = accept && (samples.operation == lpcs_pkg::OP_EVALUATE);

  assign red_ctrl.sample     = accept && (samples.operation == lpcs_pkg::OP_SAMPLE);
  assign red_ctrl.evaluate   = eval_accept;
  assign red_ctrl.level      = samples.red_level;
  assign green_ctrl.sample   = red_ctrl.sample;
  assign green_ctrl.evaluate = eval_accept;
  assign green_ctrl.level    = samples.green_level;

  lpcs_line #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_red (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (red_ctrl),
    .threshold (edge_threshold),
    .kind      (red_kind_now)
  );

  lpcs_line #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_green (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (green_ctrl),
    .threshold (edge_threshold),
    .kind      (green_kind_now)
  );

  // red wins over green
  always_comb begin
    priority if (red_kind_now != lpcs_pkg::KIND_LOW) begin
      charge_next = lpcs_pkg::STATE_FAULT;
    end else if (green_kind_now != lpcs_pkg::KIND_LOW) begin
      charge_next = lpcs_pkg::STATE_CHARGING;
    end else begin
      charge_next = lpcs_pkg::STATE_NOT_CONNECTED;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (eval_accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_accept) begin
      results.charge_state <= charge_next;
      results.red_kind     <= red_kind_now;
      results.green_kind   <= green_kind_now;
    end
  end

`ifndef SYNTH
  // an evaluate item always leaves a result behind
  a_eval_result: assert property (@(posedge clk) disable iff (rst)
    eval_accept |=> results.valid)
    else $error("evaluate item left no result");

  // reported state agrees with the reported red class
  a_fault_red: assert property (@(posedge clk) disable iff (rst)
    results.valid |->
      ((results.charge_state == lpcs_pkg::STATE_FAULT) ==
       (results.red_kind != lpcs_pkg::KIND_LOW)))
    else $error("charge state and red class disagree");

  // a fresh window classes both lines low unless the threshold is zero
  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    eval_accept |=>
      (edge_threshold == '0) ||
      ((red_kind_now == lpcs_pkg::KIND_LOW) && (green_kind_now == lpcs_pkg::KIND_LOW)))
    else $error("counters not cleared by evaluate");
`endif

endmodule

`default_nettype wire
